### rtl/trpd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// trpd_pkg
// Shared widths, register indexes and constants of the TGA RLE packet decoder.
// ----------------------------------------------------------------------------
package trpd_pkg;

    localparam int MAX_PIXELS_LOG2 = 24;

    localparam int BYTE_W          = 8;
    localparam int PIXEL_BYTES_W   = 3;
    localparam int IMAGE_PIXELS_W  = 25;
    localparam int PIXEL_VALUE_W   = 32;
    localparam int REPEAT_W        = 8;
    localparam int START_INDEX_W   = 24;
    localparam int BYTE_POS_W      = 2;
    localparam int MAX_PIXEL_BYTES = 4;

    localparam int M_TDATA_W = PIXEL_VALUE_W + REPEAT_W + START_INDEX_W;

    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = IMAGE_PIXELS_W;

    localparam int DONE_W  = MAX_PIXELS_LOG2;
    localparam int LIMIT_W = (IMAGE_PIXELS_W > MAX_PIXELS_LOG2 + 1) ?
                             IMAGE_PIXELS_W : MAX_PIXELS_LOG2 + 1;

    localparam logic [CFG_INDEX_W-1:0] REG_PIXEL_BYTES  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_PIXELS = 2'd1;

    localparam logic [PIXEL_BYTES_W-1:0]  PIXEL_BYTES_RESET  = 3'd4;
    localparam logic [IMAGE_PIXELS_W-1:0] IMAGE_PIXELS_RESET = 25'd1;

    localparam logic [BYTE_W-1:0] RUN_BIAS = 8'd127;

endpackage : trpd_pkg
`default_nettype wire

### rtl/tga_rle_packet_decoder_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tga_rle_packet_decoder_core
// Decodes a run-length coded TGA pixel stream into run tokens.
// ----------------------------------------------------------------------------
// Usage:
//   s_ channel: one compressed byte per item (packet header or pixel byte).
//   m_ channel: one run token per finished pixel: value, repeat count and
//   start index in tdata, image end in tlast, overflow in tuser.
//   cfg port: write pixel_bytes (index 0) and image_pixels (index 1) while
//   the block is idle; writes to other indexes are ignored.
// Output: the token of a pixel is registered and valid in the cycle after its
//   last byte is accepted. Headers and non-final pixel bytes give no token.
// Throughput: one byte per cycle while no token is held back by m_tready; the whole
//   per-byte decode is one pass of logic into the state and the output register.
// Reset: aresetn (synchronous, active low) clears the decoder state, drops a
//   pending token and sets pixel_bytes to 4 and image_pixels to 1.
// Stall: the output register holds its token while m_tready is low; s_tready
//   drops until that token is taken, so no byte is accepted meanwhile.
// ----------------------------------------------------------------------------
module tga_rle_packet_decoder_core (
    input  wire                                   aclk,
    input  wire                                   aresetn,

    input  wire                                   cfg_wr_en,
    input  wire [trpd_pkg::CFG_INDEX_W-1:0]       cfg_index,
    input  wire [trpd_pkg::CFG_DATA_W-1:0]        cfg_wdata,

    input  wire                                   s_tvalid,
    output logic                                  s_tready,
    input  wire [trpd_pkg::BYTE_W-1:0]            s_tdata,   // data_byte

    output logic                                  m_tvalid,
    input  wire                                   m_tready,
    // pixel_value [31:0], repeat_count [39:32], start_index [63:40]
    output logic [trpd_pkg::M_TDATA_W-1:0]        m_tdata,
    output logic                                  m_tlast,   // image_end
    output logic                                  m_tuser    // overflow
);

    typedef enum logic {
        PH_HEADER,
        PH_PIXEL
    } phase_t;

    phase_t                                      phase_reg;
    logic [trpd_pkg::REPEAT_W-1:0]               packet_left_reg;
    logic                                        run_packet_reg;
    logic [trpd_pkg::BYTE_POS_W-1:0]             byte_position_reg;
    logic [trpd_pkg::PIXEL_VALUE_W-1:0]          pixel_gather_reg;
    logic [trpd_pkg::DONE_W-1:0]                 pixels_done_reg;
    logic [trpd_pkg::PIXEL_BYTES_W-1:0]          pixel_bytes_reg;
    logic [trpd_pkg::IMAGE_PIXELS_W-1:0]         image_pixels_reg;

    logic                                        m_tvalid_reg;
    logic [trpd_pkg::PIXEL_VALUE_W-1:0]          pixel_value_reg;
    logic [trpd_pkg::REPEAT_W-1:0]               repeat_count_reg;
    logic [trpd_pkg::START_INDEX_W-1:0]          start_index_reg;
    logic                                        image_end_reg;
    logic                                        overflow_reg;

    logic                                        s_accept;
    logic [trpd_pkg::PIXEL_BYTES_W-1:0]          eff_pixel_bytes;
    logic [trpd_pkg::LIMIT_W-1:0]                pixels_ext;
    logic [trpd_pkg::LIMIT_W-1:0]                limit;
    logic [trpd_pkg::LIMIT_W-1:0]                done_ext;
    logic [trpd_pkg::LIMIT_W-1:0]                rem;
    logic [trpd_pkg::REPEAT_W-1:0]               want;
    logic [trpd_pkg::LIMIT_W-1:0]                want_ext;
    logic                                        clip;
    logic [trpd_pkg::REPEAT_W-1:0]               count;
    logic                                        ovf;
    logic                                        pixel_complete;
    logic [trpd_pkg::PIXEL_VALUE_W-1:0]          pixel_gather_next;
    logic [trpd_pkg::DONE_W-1:0]                 pixels_done_next;
    logic [trpd_pkg::REPEAT_W-1:0]               packet_left_next;

    assign s_tready = !m_tvalid_reg || m_tready;
    assign s_accept = s_tvalid && s_tready;

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {start_index_reg, repeat_count_reg, pixel_value_reg};
    assign m_tlast  = image_end_reg;
    assign m_tuser  = overflow_reg;

    always_comb begin
        if (pixel_bytes_reg == '0) begin
            eff_pixel_bytes = trpd_pkg::PIXEL_BYTES_W'(1);
        end else if (pixel_bytes_reg > trpd_pkg::PIXEL_BYTES_W'(trpd_pkg::MAX_PIXEL_BYTES)) begin
            eff_pixel_bytes = trpd_pkg::PIXEL_BYTES_W'(trpd_pkg::MAX_PIXEL_BYTES);
        end else begin
            eff_pixel_bytes = pixel_bytes_reg;
        end

        pixels_ext = trpd_pkg::LIMIT_W'(image_pixels_reg);
        if (pixels_ext == '0) begin
            limit = trpd_pkg::LIMIT_W'(1);
        end else if (pixels_ext > (trpd_pkg::LIMIT_W'(1) << trpd_pkg::MAX_PIXELS_LOG2)) begin
            limit = trpd_pkg::LIMIT_W'(1) << trpd_pkg::MAX_PIXELS_LOG2;
        end else begin
            limit = pixels_ext;
        end

        done_ext = trpd_pkg::LIMIT_W'(pixels_done_reg);
        rem      = (limit > done_ext) ? (limit - done_ext) : trpd_pkg::LIMIT_W'(1);
        want     = run_packet_reg ? packet_left_reg : trpd_pkg::REPEAT_W'(1);
        want_ext = trpd_pkg::LIMIT_W'(want);
        clip     = (want_ext >= rem);
        count    = clip ? rem[trpd_pkg::REPEAT_W-1:0] : want;
        ovf      = clip && ((want_ext > rem) ||
                            (!run_packet_reg && (packet_left_reg > trpd_pkg::REPEAT_W'(1))));

        pixel_gather_next = pixel_gather_reg |
            (trpd_pkg::PIXEL_VALUE_W'(s_tdata) << {byte_position_reg, 3'b000});
        pixel_complete = ((trpd_pkg::PIXEL_BYTES_W'(byte_position_reg) +
                           trpd_pkg::PIXEL_BYTES_W'(1)) >= eff_pixel_bytes);

        pixels_done_next = trpd_pkg::DONE_W'(done_ext + trpd_pkg::LIMIT_W'(count));
        packet_left_next = packet_left_reg - trpd_pkg::REPEAT_W'(1);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg         <= PH_HEADER;
            packet_left_reg   <= '0;
            run_packet_reg    <= 1'b0;
            byte_position_reg <= '0;
            pixel_gather_reg  <= '0;
            pixels_done_reg   <= '0;
            pixel_bytes_reg   <= trpd_pkg::PIXEL_BYTES_RESET;
            image_pixels_reg  <= trpd_pkg::IMAGE_PIXELS_RESET;
            m_tvalid_reg      <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                unique case (cfg_index)
                    trpd_pkg::REG_PIXEL_BYTES: begin
                        pixel_bytes_reg <= cfg_wdata[trpd_pkg::PIXEL_BYTES_W-1:0];
                    end
                    trpd_pkg::REG_IMAGE_PIXELS: begin
                        image_pixels_reg <= cfg_wdata[trpd_pkg::IMAGE_PIXELS_W-1:0];
                    end
                    default: begin
                    end
                endcase
            end

            if (m_tvalid_reg && m_tready) begin
                m_tvalid_reg <= 1'b0;
            end

            if (s_accept) begin
                unique case (phase_reg)
                    PH_HEADER: begin
                        run_packet_reg    <= s_tdata[trpd_pkg::BYTE_W-1];
                        packet_left_reg   <= s_tdata[trpd_pkg::BYTE_W-1] ?
                                             (s_tdata - trpd_pkg::RUN_BIAS) :
                                             (s_tdata + trpd_pkg::BYTE_W'(1));
                        byte_position_reg <= '0;
                        pixel_gather_reg  <= '0;
                        phase_reg         <= PH_PIXEL;
                    end
                    PH_PIXEL: begin
                        if (!pixel_complete) begin
                            pixel_gather_reg  <= pixel_gather_next;
                            byte_position_reg <= byte_position_reg + trpd_pkg::BYTE_POS_W'(1);
                        end else begin
                            m_tvalid_reg      <= 1'b1;
                            pixel_value_reg   <= pixel_gather_next;
                            repeat_count_reg  <= count;
                            start_index_reg   <= trpd_pkg::START_INDEX_W'(pixels_done_reg);
                            image_end_reg     <= clip;
                            overflow_reg      <= ovf;
                            byte_position_reg <= '0;
                            pixel_gather_reg  <= '0;
                            if (clip) begin
                                pixels_done_reg <= '0;
                                packet_left_reg <= '0;
                                phase_reg       <= PH_HEADER;
                            end else begin
                                pixels_done_reg <= pixels_done_next;
                                if (run_packet_reg) begin
                                    packet_left_reg <= '0;
                                    phase_reg       <= PH_HEADER;
                                end else begin
                                    packet_left_reg <= packet_left_next;
                                    if (packet_left_next == '0) begin
                                        phase_reg <= PH_HEADER;
                                    end
                                end
                            end
                        end
                    end
                    default: begin
                        phase_reg <= PH_HEADER;
                    end
                endcase
            end
        end
    end

    a_ovf_ends_image: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> m_tlast)
        else $error("overflow token without image end");

    a_count_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[trpd_pkg::PIXEL_VALUE_W +: trpd_pkg::REPEAT_W] != '0))
        else $error("token with zero repeat count");

    a_phase_left: assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg == PH_HEADER) == (packet_left_reg == '0))
        else $error("packet count out of step with phase");

    a_header_pos: assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg == PH_HEADER) |-> (byte_position_reg == '0))
        else $error("byte position nonzero while awaiting header");

endmodule : tga_rle_packet_decoder_core
`default_nettype wire

### tb/tga_rle_packet_decoder_core_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tga_rle_packet_decoder_core_test
// Self-checking bench for the TGA run-length packet decoder.
// A byte driver streams directed and random compressed images into the block.
// An in-bench decoder predicts each run token at byte acceptance, and a
// monitor compares every token taken from the block field by field. Register
// settings change between phases while the stream is drained, and both
// stream sides pause at random rates.
// ----------------------------------------------------------------------------
module tga_rle_packet_decoder_core_test;

    localparam logic [trpd_pkg::CFG_INDEX_W-1:0] REG_SPARE_A = 2'd2;
    localparam logic [trpd_pkg::CFG_INDEX_W-1:0] REG_SPARE_B = 2'd3;
    localparam logic [trpd_pkg::BYTE_W-1:0]      RUN_HEADER  = 8'd128;
    localparam int                               QUIET_LIMIT = 5000;
    localparam int                               NUM_PHASES  = 9;

    typedef struct packed {
        logic [trpd_pkg::PIXEL_VALUE_W-1:0] pixel_value;
        logic [trpd_pkg::REPEAT_W-1:0]      repeat_count;
        logic [trpd_pkg::START_INDEX_W-1:0] start_index;
        logic                               image_end;
        logic                               overflow;
    } run_token_t;

    logic                                aclk      = 1'b0;
    logic                                aresetn   = 1'b0;
    logic                                cfg_wr_en = 1'b0;
    logic [trpd_pkg::CFG_INDEX_W-1:0]    cfg_index = '0;
    logic [trpd_pkg::CFG_DATA_W-1:0]     cfg_wdata = '0;
    logic                                s_tvalid  = 1'b0;
    logic                                s_tready;
    logic [trpd_pkg::BYTE_W-1:0]         s_tdata   = '0;   // data_byte
    logic                                m_tvalid;
    logic                                m_tready  = 1'b0;
    // pixel_value [31:0], repeat_count [39:32], start_index [63:40]
    logic [trpd_pkg::M_TDATA_W-1:0]      m_tdata;
    logic                                m_tlast;          // image_end
    logic                                m_tuser;          // overflow

    tga_rle_packet_decoder_core u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser)
    );

    // decoder model state
    logic [trpd_pkg::PIXEL_BYTES_W-1:0]  pix_bytes_reg  = trpd_pkg::PIXEL_BYTES_RESET;
    logic [trpd_pkg::IMAGE_PIXELS_W-1:0] img_pixels_reg = trpd_pkg::IMAGE_PIXELS_RESET;
    logic                                in_packet      = 1'b0;
    logic [trpd_pkg::BYTE_W-1:0]         pkt_left       = '0;
    logic                                pkt_is_run     = 1'b0;
    logic [trpd_pkg::BYTE_POS_W-1:0]     byte_pos       = '0;
    logic [trpd_pkg::PIXEL_VALUE_W-1:0]  gather         = '0;
    logic [trpd_pkg::IMAGE_PIXELS_W-1:0] pixels_done    = '0;

    logic [trpd_pkg::BYTE_W-1:0] pending_bytes[$];
    run_token_t                  expected_tokens[$];
    run_token_t                  next_token;
    run_token_t                  exp_token;

    int bytes_queued   = 0;
    int bytes_taken    = 0;
    int tokens_seen    = 0;
    int ends_seen      = 0;
    int clipped_seen   = 0;
    int mismatches     = 0;
    int settings_used  = 0;
    int quiet_cycles   = 0;
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;

    int unsigned                     phase_pb[NUM_PHASES]   = '{1, 2, 3, 4, 5, 6, 0, 7, 4};
    logic [trpd_pkg::CFG_DATA_W-1:0] phase_np[NUM_PHASES]   =
        '{25'd1, 25'd7, 25'd40, 25'd300, 25'd16, 25'd0, 25'd3, 25'h1FFFFFF, 25'd2};
    int                              phase_send[NUM_PHASES] = '{0, 48, 0, 28, 0, 48, 0, 28, 0};
    int                              phase_recv[NUM_PHASES] = '{0, 0, 48, 28, 0, 0, 48, 28, 0};

    function automatic int unsigned eff_width(logic [trpd_pkg::PIXEL_BYTES_W-1:0] pb);
        if (pb == 0) return 1;
        if (pb > trpd_pkg::MAX_PIXEL_BYTES) return trpd_pkg::MAX_PIXEL_BYTES;
        return 32'(pb);
    endfunction

    function automatic longint unsigned eff_limit(logic [trpd_pkg::IMAGE_PIXELS_W-1:0] np);
        longint unsigned cap;
        cap = 64'd1 << trpd_pkg::MAX_PIXELS_LOG2;
        if (np == 0) return 1;
        if (np > cap) return cap;
        return 64'(np);
    endfunction

    function automatic bit decode_byte(input logic [trpd_pkg::BYTE_W-1:0] b,
                                       output run_token_t tok);
        longint unsigned limit, rem, want, count;
        bit fin, ovf;
        tok = '0;
        if (!in_packet) begin
            if (b < RUN_HEADER) begin
                pkt_is_run = 1'b0;
                pkt_left   = b + 8'd1;
            end else begin
                pkt_is_run = 1'b1;
                pkt_left   = b - trpd_pkg::RUN_BIAS;
            end
            byte_pos  = '0;
            gather    = '0;
            in_packet = 1'b1;
            return 1'b0;
        end
        gather |= trpd_pkg::PIXEL_VALUE_W'(b) << (8 * byte_pos);
        if (byte_pos + 1 < eff_width(pix_bytes_reg)) begin
            byte_pos = byte_pos + 1'b1;
            return 1'b0;
        end
        limit = eff_limit(img_pixels_reg);
        rem   = (limit > pixels_done) ? limit - pixels_done : 1;
        want  = pkt_is_run ? pkt_left : 1;
        count = want;
        fin   = 1'b0;
        ovf   = 1'b0;
        if (count >= rem) begin
            count = rem;
            fin   = 1'b1;
            if (want > rem || (!pkt_is_run && pkt_left > 1)) ovf = 1'b1;
        end
        tok.pixel_value  = gather;
        tok.repeat_count = trpd_pkg::REPEAT_W'(count);
        tok.start_index  = pixels_done[trpd_pkg::START_INDEX_W-1:0];
        tok.image_end    = fin;
        tok.overflow     = ovf;
        byte_pos = '0;
        gather   = '0;
        if (fin) begin
            pixels_done = '0;
            pkt_left    = '0;
            in_packet   = 1'b0;
        end else begin
            pixels_done = trpd_pkg::IMAGE_PIXELS_W'(pixels_done + count);
            if (pkt_is_run) begin
                pkt_left  = '0;
                in_packet = 1'b0;
            end else begin
                pkt_left = pkt_left - 8'd1;
                if (pkt_left == 0) in_packet = 1'b0;
            end
        end
        return 1'b1;
    endfunction

    initial begin
        forever #10 aclk = ~aclk;
    end

    // byte driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                bytes_taken++;
                if (decode_byte(s_tdata, next_token)) expected_tokens.push_back(next_token);
            end
            if (!s_tvalid || s_tready) begin
                if (pending_bytes.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                    s_tvalid <= 1'b1;
                    s_tdata  <= pending_bytes.pop_front();
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // token monitor
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                tokens_seen++;
                if (expected_tokens.size() == 0) begin
                    $error("unexpected token %h last %b user %b", m_tdata, m_tlast, m_tuser);
                    mismatches++;
                end else begin
                    exp_token = expected_tokens.pop_front();
                    if (exp_token.image_end) ends_seen++;
                    if (exp_token.overflow) clipped_seen++;
                    if (m_tdata[31:0] !== exp_token.pixel_value) begin
                        $error("pixel_value expected %h got %h",
                               exp_token.pixel_value, m_tdata[31:0]);
                        mismatches++;
                    end
                    if (m_tdata[39:32] !== exp_token.repeat_count) begin
                        $error("repeat_count expected %0d got %0d",
                               exp_token.repeat_count, m_tdata[39:32]);
                        mismatches++;
                    end
                    if (m_tdata[63:40] !== exp_token.start_index) begin
                        $error("start_index expected %0d got %0d",
                               exp_token.start_index, m_tdata[63:40]);
                        mismatches++;
                    end
                    if (m_tlast !== exp_token.image_end) begin
                        $error("image_end expected %b got %b", exp_token.image_end, m_tlast);
                        mismatches++;
                    end
                    if (m_tuser !== exp_token.overflow) begin
                        $error("overflow expected %b got %b", exp_token.overflow, m_tuser);
                        mismatches++;
                    end
                end
            end
            m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    // watchdog on handshake activity
    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_wr_en) begin
                quiet_cycles <= 0;
            end else if (quiet_cycles >= QUIET_LIMIT) begin
                $display("watchdog: no progress, %0d tokens outstanding",
                         expected_tokens.size());
                $display("SCOREBOARD MISMATCH");
                $finish;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    task automatic push_byte(input logic [trpd_pkg::BYTE_W-1:0] b);
        pending_bytes.push_back(b);
        bytes_queued++;
    endtask

    task automatic set_reg(input logic [trpd_pkg::CFG_INDEX_W-1:0] idx,
                           input logic [trpd_pkg::CFG_DATA_W-1:0] val);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        if (idx == trpd_pkg::REG_PIXEL_BYTES) begin
            pix_bytes_reg = val[trpd_pkg::PIXEL_BYTES_W-1:0];
        end else if (idx == trpd_pkg::REG_IMAGE_PIXELS) begin
            img_pixels_reg = val;
        end
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        @(negedge aclk);
    endtask

    task automatic wait_drained();
        do @(negedge aclk);
        while (bytes_taken != bytes_queued || expected_tokens.size() != 0 || s_tvalid);
        repeat (3) @(negedge aclk);
    endtask

    task automatic queue_pixel(input int unsigned width);
        int pick;
        repeat (width) begin
            pick = $urandom_range(0, 9);
            if (pick == 0) push_byte(8'h00);
            else if (pick == 1) push_byte(8'hFF);
            else push_byte(trpd_pkg::BYTE_W'($urandom_range(0, 255)));
        end
    endtask

    task automatic queue_image(input int unsigned width, input longint unsigned npix,
                               input int stop_at);
        longint unsigned left;
        int len, max_len, shown, room;
        left = npix;
        while (left > 0 && bytes_queued < stop_at) begin
            max_len = (left < 128) ? int'(left) : 128;
            if ($urandom_range(0, 9) == 0) len = $urandom_range(1, 128);
            else if ($urandom_range(0, 1)) len = $urandom_range(1, (max_len < 4) ? max_len : 4);
            else len = $urandom_range(1, max_len);
            if ($urandom_range(0, 1)) begin
                push_byte(trpd_pkg::BYTE_W'(trpd_pkg::RUN_BIAS + len));
                queue_pixel(width);
                left = (len >= left) ? 0 : left - len;
            end else begin
                // keep a raw packet inside the byte budget of the phase
                room = (stop_at - bytes_queued) / int'(width);
                if (room < 1) room = 1;
                if (len > room) len = room;
                push_byte(trpd_pkg::BYTE_W'(len - 1));
                shown = (len < left) ? len : int'(left);
                repeat (shown) queue_pixel(width);
                left -= shown;
            end
        end
    endtask

    initial begin
        int stop_at;

        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // raw overrun, clipped run, exact fill
        set_reg(trpd_pkg::REG_PIXEL_BYTES, 25'd1);
        set_reg(trpd_pkg::REG_IMAGE_PIXELS, 25'd5);
        settings_used++;
        push_byte(8'h7F); push_byte(8'h00); push_byte(8'hFF); push_byte(8'h01);
        push_byte(8'h80); push_byte(8'h7E);
        push_byte(8'hFF); push_byte(8'h5A);
        push_byte(8'h80); push_byte(8'h00);
        push_byte(8'h00); push_byte(8'hFF);
        push_byte(8'h82); push_byte(8'h33);
        wait_drained();
        // shrink the image below the pixels already done
        set_reg(trpd_pkg::REG_IMAGE_PIXELS, 25'd10);
        push_byte(8'h83); push_byte(8'h11);
        wait_drained();
        set_reg(trpd_pkg::REG_IMAGE_PIXELS, 25'd2);
        settings_used++;
        push_byte(8'h85); push_byte(8'h22);
        wait_drained();
        // out-of-range register values
        set_reg(trpd_pkg::REG_PIXEL_BYTES, 25'd0);
        set_reg(trpd_pkg::REG_IMAGE_PIXELS, 25'd0);
        settings_used++;
        push_byte(8'h00); push_byte(8'hC3);
        wait_drained();
        set_reg(trpd_pkg::REG_PIXEL_BYTES, 25'd7);
        set_reg(trpd_pkg::REG_IMAGE_PIXELS, 25'h1FFFFFF);
        settings_used++;
        push_byte(8'h80); push_byte(8'h01); push_byte(8'h02); push_byte(8'h03);
        push_byte(8'h04);
        wait_drained();

        for (int p = 0; p < NUM_PHASES; p++) begin
            set_reg(trpd_pkg::REG_PIXEL_BYTES, trpd_pkg::CFG_DATA_W'(phase_pb[p]));
            set_reg(trpd_pkg::REG_IMAGE_PIXELS, phase_np[p]);
            if (p == 2) set_reg(REG_SPARE_A, 25'h1FFFFFF);
            if (p == 5) set_reg(REG_SPARE_B, 25'h0AAAAAA);
            settings_used++;
            send_idle_pct  = phase_send[p];
            recv_stall_pct = phase_recv[p];
            stop_at = bytes_queued + 70;
            while (bytes_queued < stop_at) begin
                if (p == 4 && bytes_queued >= stop_at - 35 && bytes_queued < stop_at - 30) begin
                    // hold the stream until every token is out
                    wait_drained();
                end
                if ($urandom_range(0, 9) < 8) begin
                    queue_image(eff_width(trpd_pkg::PIXEL_BYTES_W'(phase_pb[p])),
                                eff_limit(phase_np[p]), stop_at);
                end else begin
                    repeat ($urandom_range(1, 6)) begin
                        push_byte(trpd_pkg::BYTE_W'($urandom_range(0, 255)));
                    end
                end
            end
            wait_drained();
        end

        repeat (5) @(negedge aclk);
        if (expected_tokens.size() != 0) begin
            $error("%0d expected tokens never arrived", expected_tokens.size());
            mismatches++;
        end
        $display("Streamed %0d bytes across %0d register settings and four idle mixes.",
                 bytes_taken, settings_used);
        $display("Checked %0d run tokens: %0d image ends, %0d clipped by overflow.",
                 tokens_seen, ends_seen, clipped_seen);
        if (mismatches == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

### filelist.f
rtl/trpd_pkg.sv
rtl/tga_rle_packet_decoder_core.sv
tb/tga_rle_packet_decoder_core_test.sv
